>>> rtl/dns_name_label_encoder_defines.svh
// Assertion helpers for the DNS label encoder.
`ifndef DNS_NAME_LABEL_ENCODER_DEFINES_SVH
`define DNS_NAME_LABEL_ENCODER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DNLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define DNLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/dnle_pkg.sv
`timescale 1ns / 1ps
package dnle_pkg;

	localparam int unsigned STORE_DEPTH = 63;
	localparam int unsigned CNT_W       = 6;
	localparam int unsigned CMDQ_DEPTH  = 2;
	localparam int unsigned CMDQ_PTR_W  = 1;
	localparam int unsigned CMDQ_CNT_W  = 2;

	localparam logic [7:0] CHAR_END = 8'h00;
	localparam logic [7:0] CHAR_DOT = 8'h2e;

	typedef enum logic {
		CMD_LABEL = 1'b0,
		CMD_END   = 1'b1
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t        kind;
		logic [CNT_W-1:0] len;
		logic             ovf;
	} cmd_t;

	typedef struct packed {
		logic             en;
		logic [CNT_W-1:0] addr;
		logic [7:0]       data;
	} store_wr_t;

	typedef enum logic {
		BK_IDLE = 1'b0,
		BK_DATA = 1'b1
	} bk_state_t;

endpackage

>>> rtl/dnle_front.sv
`timescale 1ns / 1ps
module dnle_front import dnle_pkg::*; #(
	parameter int unsigned MAX_LABEL = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] in_byte,
	output logic       full,
	input  logic       cmdq_full,
	input  logic       label_done,
	output logic       cmd_push,
	output cmd_t       cmd,
	output store_wr_t  wr
);

	localparam int unsigned LABEL_LIMIT = (MAX_LABEL > STORE_DEPTH) ? STORE_DEPTH : MAX_LABEL;

	logic [CNT_W-1:0] count_q;
	logic             ovf_q;
	logic             pending_q;
	logic             accept;
	logic             is_end;
	logic             is_dot;
	logic             room;

	assign full   = pending_q || cmdq_full;
	assign accept = push && !full;
	assign is_end = (in_byte == CHAR_END);
	assign is_dot = (in_byte == CHAR_DOT);
	assign room   = (count_q < CNT_W'(LABEL_LIMIT));

	always_comb begin
		cmd_push = 1'b0;
		cmd.kind = CMD_END;
		cmd.len  = count_q;
		cmd.ovf  = ovf_q;
		wr.en    = 1'b0;
		wr.addr  = count_q;
		wr.data  = in_byte;
		if (accept) begin
			if (is_end) begin
				cmd_push = 1'b1;
			end else if (is_dot) begin
				cmd_push = (count_q != '0);
				cmd.kind = CMD_LABEL;
			end else begin
				wr.en = room;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			ovf_q     <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			if (label_done) begin
				pending_q <= 1'b0;
			end
			if (accept) begin
				if (is_end) begin
					count_q <= '0;
					ovf_q   <= 1'b0;
				end else if (is_dot) begin
					if (count_q != '0) begin
						count_q   <= '0;
						pending_q <= 1'b1;
					end
				end else if (room) begin
					count_q <= count_q + 1'b1;
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/dnle_cmd_q.sv
`timescale 1ns / 1ps
module dnle_cmd_q import dnle_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  cmd_t wr_cmd,
	output logic full,
	input  logic rd_en,
	output cmd_t rd_cmd,
	output logic empty
);

	cmd_t                  slot_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wptr_q;
	logic [CMDQ_PTR_W-1:0] rptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  do_wr;
	logic                  do_rd;

	assign full   = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign empty  = (cnt_q == '0);
	assign do_wr  = wr_en && !full;
	assign do_rd  = rd_en && !empty;
	assign rd_cmd = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/dnle_back.sv
`timescale 1ns / 1ps
`include "dns_name_label_encoder_defines.svh"
module dnle_back import dnle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  store_wr_t  wr,
	input  logic       cmd_empty,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	output logic       label_done,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       last,
	output logic       label_too_long
);

	logic [7:0]       store_q [STORE_DEPTH];
	logic [7:0]       rd_q;
	bk_state_t        state_q;
	bk_state_t        state_d;
	logic [CNT_W-1:0] idx_q;
	logic [CNT_W-1:0] idx_d;
	logic [CNT_W-1:0] len_q;
	logic             ovf_q;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             last_q;
	logic             too_long_q;
	logic             slot_free;
	logic             load;
	logic [7:0]       load_byte;
	logic             load_last;
	logic             load_ovf;
	logic             at_end;

	assign slot_free      = !out_valid_q || pop;
	assign at_end         = (idx_q == len_q - 1'b1);
	assign empty          = !out_valid_q;
	assign out_byte       = out_byte_q;
	assign last           = last_q;
	assign label_too_long = too_long_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: begin
				if (!cmd_empty && slot_free && cmd.kind == CMD_LABEL) begin
					state_d = BK_DATA;
				end
			end
			BK_DATA: begin
				if (slot_free && at_end) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		cmd_pop    = 1'b0;
		label_done = 1'b0;
		load       = 1'b0;
		load_byte  = rd_q;
		load_last  = 1'b0;
		load_ovf   = ovf_q;
		idx_d      = '0;
		unique case (state_q)
			BK_IDLE: begin
				if (!cmd_empty && slot_free) begin
					cmd_pop  = 1'b1;
					load     = 1'b1;
					load_ovf = cmd.ovf;
					if (cmd.kind == CMD_END) begin
						load_byte = CHAR_END;
						load_last = 1'b1;
					end else begin
						load_byte = 8'(cmd.len);
					end
				end
			end
			BK_DATA: begin
				idx_d = idx_q;
				if (slot_free) begin
					load = 1'b1;
					if (at_end) begin
						label_done = 1'b1;
						idx_d      = '0;
					end else begin
						idx_d = idx_q + 1'b1;
					end
				end
			end
			default: begin
				idx_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			store_q[wr.addr] <= wr.data;
		end
		rd_q <= store_q[idx_d];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			len_q <= cmd.len;
			ovf_q <= cmd.ovf;
		end
		if (load) begin
			out_byte_q <= load_byte;
			last_q     <= load_last;
			too_long_q <= load_ovf;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`DNLE_ASSERT_NOW(a_idx_in_label, state_q == BK_DATA, idx_q < len_q, "replay index past label")
	`DNLE_ASSERT_NOW(a_len_nonzero, state_q == BK_DATA, len_q != '0, "empty label replayed")
	`DNLE_ASSERT_NEXT(a_done_idle, label_done, state_q == BK_IDLE && out_valid_q,
		"label end not followed by idle")

endmodule

>>> rtl/dns_name_label_encoder.sv
`timescale 1ns / 1ps
// A zero byte goes through the command queue and the output register to show the root byte;
// a dot closing a non-empty label shows its length byte the same way, then one label
// character per cycle while out_byte is popped. Character bytes are accepted whenever full
// is low; a closing dot holds input until the back end replays the label from the store.
// Reset: arst_n clears count, flags, command queue and output valid; the store and output data are not cleared.
module dns_name_label_encoder import dnle_pkg::*; #(
	parameter int unsigned MAX_LABEL = 63
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] in_byte,
	output logic       full,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] out_byte,
	output logic       last,
	output logic       label_too_long
);

	logic      cmdq_full;
	logic      cmdq_empty;
	logic      cmd_push;
	logic      cmd_pop;
	logic      label_done;
	cmd_t      cmd_in;
	cmd_t      cmd_out;
	store_wr_t wr;

	dnle_front #(
		.MAX_LABEL(MAX_LABEL)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.in_byte    (in_byte),
		.full       (full),
		.cmdq_full  (cmdq_full),
		.label_done (label_done),
		.cmd_push   (cmd_push),
		.cmd        (cmd_in),
		.wr         (wr)
	);

	dnle_cmd_q u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cmd_push),
		.wr_cmd (cmd_in),
		.full   (cmdq_full),
		.rd_en  (cmd_pop),
		.rd_cmd (cmd_out),
		.empty  (cmdq_empty)
	);

	dnle_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.wr             (wr),
		.cmd_empty      (cmdq_empty),
		.cmd            (cmd_out),
		.cmd_pop        (cmd_pop),
		.label_done     (label_done),
		.pop            (pop),
		.empty          (empty),
		.out_byte       (out_byte),
		.last           (last),
		.label_too_long (label_too_long)
	);

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import dnle_pkg::*;

	localparam int unsigned MAX_LABEL   = 63;
	localparam int unsigned LABEL_LIMIT = (MAX_LABEL > STORE_DEPTH) ? STORE_DEPTH : MAX_LABEL;
	localparam int          RAND_ITEMS  = 160;
	localparam int          STALL_LEN   = 300;
	localparam int          QUIET_LIMIT = 2000;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       too_long;
	} wire_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] in_byte = 8'h00;
	logic       full;
	logic       pop = 1'b0;
	logic       empty;
	logic [7:0] out_byte;
	logic       last;
	logic       label_too_long;

	logic [7:0] name_q[$];
	wire_byte_t wire_q[$];
	wire_byte_t want;

	logic [7:0] label_buf[STORE_DEPTH];
	int         label_len = 0;
	logic       trunc_seen = 1'b0;

	int   in_cnt = 0;
	int   errors = 0;
	int   stall_left = 0;
	logic stall_done = 1'b0;
	int   quiet = 0;
	logic calm;

	assign calm = (in_cnt >= 40) && (in_cnt < 100);

	dns_name_label_encoder #(
		.MAX_LABEL(MAX_LABEL)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.in_byte       (in_byte),
		.full          (full),
		.pop           (pop),
		.empty         (empty),
		.out_byte      (out_byte),
		.last          (last),
		.label_too_long(label_too_long)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void emit_wire_byte(logic [7:0] d, logic l);
		wire_byte_t w;
		w.data     = d;
		w.last     = l;
		w.too_long = trunc_seen;
		wire_q.push_back(w);
	endfunction

	// wire-form encoder: label bytes are buffered until a dot closes the label
	function automatic void encode_byte(logic [7:0] b);
		if (b == CHAR_END) begin
			emit_wire_byte(CHAR_END, 1'b1);
			label_len  = 0;
			trunc_seen = 1'b0;
		end else if (b == CHAR_DOT) begin
			if (label_len != 0) begin
				emit_wire_byte(8'(label_len), 1'b0);
				for (int i = 0; i < label_len; i++)
					emit_wire_byte(label_buf[i], 1'b0);
				label_len = 0;
			end
		end else if (label_len < LABEL_LIMIT) begin
			label_buf[label_len] = b;
			label_len++;
		end else begin
			trunc_seen = 1'b1;
		end
	endfunction

	function automatic logic [7:0] rand_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c == CHAR_DOT);
		return c;
	endfunction

	task automatic add_label(int n);
		for (int i = 0; i < n; i++)
			name_q.push_back(rand_char());
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full) begin
				encode_byte(in_byte);
				void'(name_q.pop_front());
				in_cnt <= in_cnt + 1;
			end
			if (!(push && full)) begin
				if (name_q.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
					push    <= 1'b1;
					in_byte <= name_q[0];
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (wire_q.size() == 0) begin
					$display("%0t: unexpected result out_byte=%h last=%b label_too_long=%b",
						$time, out_byte, last, label_too_long);
					errors++;
				end else begin
					want = wire_q.pop_front();
					if (out_byte !== want.data) begin
						$display("%0t: out_byte expected %h actual %h", $time, want.data, out_byte);
						errors++;
					end
					if (last !== want.last) begin
						$display("%0t: last expected %b actual %b", $time, want.last, last);
						errors++;
					end
					if (label_too_long !== want.too_long) begin
						$display("%0t: label_too_long expected %b actual %b",
							$time, want.too_long, label_too_long);
						errors++;
					end
				end
			end
			if (!stall_done && in_cnt >= 110) begin
				stall_left = STALL_LEN;
				stall_done = 1'b1;
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else begin
				pop <= calm || ($urandom_range(0, 99) >= 7);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		int nlab;
		int r;

		// empty name, lone dot, leading and doubled dots, unclosed trailing labels
		name_q = {CHAR_END,
			CHAR_DOT, CHAR_END,
			CHAR_DOT, 8'h01, 8'hFF, CHAR_DOT, CHAR_DOT, 8'h41, CHAR_DOT, 8'h7F, 8'h80, CHAR_END,
			8'hFE, 8'h55, 8'hAA, CHAR_END,
			8'h2D, 8'h2F, CHAR_DOT, CHAR_END};

		// overlong label: truncated, flag held through the next label and the root
		add_label(64);
		name_q.push_back(CHAR_DOT);
		add_label(2);
		name_q.push_back(CHAR_DOT);
		name_q.push_back(CHAR_END);

		while (name_q.size() < RAND_ITEMS) begin
			if ($urandom_range(0, 99) < 10) begin
				nlab = $urandom_range(1, 12);
				for (int i = 0; i < nlab; i++)
					name_q.push_back(($urandom_range(0, 99) < 30) ? CHAR_DOT : rand_char());
			end else begin
				nlab = $urandom_range(0, 4);
				for (int i = 0; i < nlab; i++) begin
					r = $urandom_range(0, 99);
					if (r < 8)
						;
					else if (r < 12)
						add_label($urandom_range(60, 70));
					else
						add_label($urandom_range(1, 10));
					name_q.push_back(CHAR_DOT);
				end
				if ($urandom_range(0, 99) < 25)
					add_label($urandom_range(1, 5));
			end
			name_q.push_back(CHAR_END);
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (name_q.size() != 0 || wire_q.size() != 0);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
